FILE: src/assert_macros.svh
// Assertion macros shared by the Sobel magnitude stream RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sobel magnitude stream: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SGM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sobel magnitude stream: next-cycle check failed");

`endif

FILE: src/sgm_pkg.sv
// Shared constants for the Sobel gradient magnitude stream.
package sgm_pkg;

    // Line store depth: the widest image row the block can hold.
    localparam int MAX_WIDTH = 1024;

    // Column counter and line store address width.
    localparam int CNT_W = $clog2(MAX_WIDTH);

    localparam int PIX_W    = 8;
    localparam int CFG_WW   = 11;
    localparam int CFG_HW   = 16;
    localparam int CFG_DW   = 16;
    localparam int ROW_W    = 16;

    // Width used for column versus row width compares.
    localparam int WCMP_W = (CNT_W + 1 > CFG_WW) ? CNT_W + 1 : CFG_WW;

    // Gradient and energy widths: |G| <= 1020, G*G + G*G < 2**21.
    localparam int GRAD_W   = 11;
    localparam int ENERGY_W = 21;
    localparam int ROOT_IN_W = 2 * PIX_W;

    // Configuration register indexes.
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam logic [CFG_WW-1:0] WIDTH_RESET  = CFG_WW'(640);
    localparam logic [CFG_HW-1:0] HEIGHT_RESET = CFG_HW'(480);

    localparam logic [PIX_W-1:0] MAG_SAT = {PIX_W{1'b1}};

endpackage

FILE: src/sobel_gradient_magnitude_stream.sv
// Top level of the streaming 3x3 Sobel gradient magnitude filter.
//
//   channel   direction  handshake              payload
//   -------   ---------  ---------------------  ----------------------
//   pixel in  input      i_valid / o_stall      i_pixel
//   result    output     o_valid / i_stall      o_magnitude, o_last
//   config    input      i_cfg_we (no wait)     i_cfg_index, i_cfg_data
//
// A pixel beat is taken only in the idle state, so one pixel is in flight
// at a time. A border pixel passes through the line store read, then the
// update. An interior pixel passes through read, gradient and energy, then
// the bit-serial square root unit, which resolves one result bit a cycle.
// The result sits in an output register, so the next pixel beat is taken
// while a result is still waiting; a result stalls the sequencer only when
// the previous one has not been taken yet.
// Reset is synchronous and active low; it clears the counters, the window,
// the sequencer and the output valid. The line store is not cleared: every
// entry is written on a row before the rows below read it.
module sobel_gradient_magnitude_stream (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Pixel input channel.
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [sgm_pkg::PIX_W-1:0]     i_pixel,
    // Result output channel.
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sgm_pkg::PIX_W-1:0]     o_magnitude,
    output logic                          o_last,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [sgm_pkg::CFG_DW-1:0]    i_cfg_data
);

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_ENERGY,
        ST_SQRT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [sgm_pkg::CFG_WW-1:0] r_cfg_width;
    logic [sgm_pkg::CFG_HW-1:0] r_cfg_height;

    // Position of the next pixel.
    logic [sgm_pkg::CNT_W-1:0]  r_col;
    logic [sgm_pkg::ROW_W-1:0]  r_row;

    // Two previous columns: older one in the upper half, rows top to bottom
    // from the low byte up.
    logic [6*sgm_pkg::PIX_W-1:0] r_window;

    // Line store: upper row in the low byte, middle row in the high byte.
    logic [2*sgm_pkg::PIX_W-1:0] mem_line [sgm_pkg::MAX_WIDTH];
    logic [2*sgm_pkg::PIX_W-1:0] r_rd;
    logic [sgm_pkg::PIX_W-1:0]   r_pix;

    logic signed [sgm_pkg::GRAD_W-1:0] r_gx;
    logic signed [sgm_pkg::GRAD_W-1:0] r_gy;
    logic                              r_last_pend;
    logic                              r_sat;

    logic                         r_out_valid;
    logic [sgm_pkg::PIX_W-1:0]    r_out_mag;
    logic                         r_out_last;

    logic w_in_accept;
    logic w_out_take;
    logic w_result_ready;
    logic w_load_out;

    // Effective row width and height after clamping.
    logic [sgm_pkg::WCMP_W-1:0] w_width;
    logic [sgm_pkg::WCMP_W-1:0] w_width_cfg;
    logic [sgm_pkg::CFG_HW-1:0] w_height;
    logic                       w_row_end;
    logic                       w_img_end;
    logic                       w_interior;

    // Window pixels: column 0 oldest, column 2 the one arriving now.
    logic [sgm_pkg::PIX_W-1:0] w_p00, w_p01, w_p02;
    logic [sgm_pkg::PIX_W-1:0] w_p10, w_p11, w_p12;
    logic [sgm_pkg::PIX_W-1:0] w_p20, w_p21, w_p22;
    logic signed [sgm_pkg::GRAD_W:0] w_gx;
    logic signed [sgm_pkg::GRAD_W:0] w_gy;

    logic signed [2*sgm_pkg::GRAD_W-1:0] w_gx2;
    logic signed [2*sgm_pkg::GRAD_W-1:0] w_gy2;
    logic [sgm_pkg::ENERGY_W-1:0]        w_energy;

    logic                      w_sqrt_busy;
    logic [sgm_pkg::PIX_W-1:0] w_sqrt_root;

    assign w_in_accept = i_valid && !o_stall;
    assign w_out_take  = r_out_valid && !i_stall;
    assign o_stall     = (r_state != ST_IDLE);

    // Clamp the configured geometry to the legal range.
    assign w_width_cfg = sgm_pkg::WCMP_W'(r_cfg_width);
    always_comb begin
        if (w_width_cfg < sgm_pkg::WCMP_W'(3)) begin
            w_width = sgm_pkg::WCMP_W'(3);
        end else if (w_width_cfg > sgm_pkg::WCMP_W'(sgm_pkg::MAX_WIDTH)) begin
            w_width = sgm_pkg::WCMP_W'(sgm_pkg::MAX_WIDTH);
        end else begin
            w_width = w_width_cfg;
        end
    end

    assign w_height  = (r_cfg_height < sgm_pkg::CFG_HW'(3)) ?
                       sgm_pkg::CFG_HW'(3) : r_cfg_height;
    // The column may lie past the end after a width change; that ends the row.
    assign w_row_end = (sgm_pkg::WCMP_W'(r_col) >= (w_width - sgm_pkg::WCMP_W'(1)));
    assign w_img_end = (r_row >= (w_height - sgm_pkg::CFG_HW'(1)));
    assign w_interior = (r_col >= sgm_pkg::CNT_W'(2)) && (r_row >= sgm_pkg::ROW_W'(2));

    assign w_p00 = r_window[4*sgm_pkg::PIX_W-1:3*sgm_pkg::PIX_W];
    assign w_p10 = r_window[5*sgm_pkg::PIX_W-1:4*sgm_pkg::PIX_W];
    assign w_p20 = r_window[6*sgm_pkg::PIX_W-1:5*sgm_pkg::PIX_W];
    assign w_p01 = r_window[sgm_pkg::PIX_W-1:0];
    assign w_p11 = r_window[2*sgm_pkg::PIX_W-1:sgm_pkg::PIX_W];
    assign w_p21 = r_window[3*sgm_pkg::PIX_W-1:2*sgm_pkg::PIX_W];
    assign w_p02 = r_rd[sgm_pkg::PIX_W-1:0];
    assign w_p12 = r_rd[2*sgm_pkg::PIX_W-1:sgm_pkg::PIX_W];
    assign w_p22 = r_pix;

    // Sobel X: right column minus left column, middle row weighted by two.
    // Sobel Y: bottom row minus top row, middle column weighted by two.
    always_comb begin
        w_gx = $signed({4'b0, w_p02}) - $signed({4'b0, w_p00})
             + $signed({3'b0, w_p12, 1'b0}) - $signed({3'b0, w_p10, 1'b0})
             + $signed({4'b0, w_p22}) - $signed({4'b0, w_p20});
        w_gy = $signed({4'b0, w_p20}) + $signed({3'b0, w_p21, 1'b0})
             + $signed({4'b0, w_p22})
             - $signed({4'b0, w_p00}) - $signed({3'b0, w_p01, 1'b0})
             - $signed({4'b0, w_p02});
    end

    assign w_gx2    = r_gx * r_gx;
    assign w_gy2    = r_gy * r_gy;
    assign w_energy = w_gx2[sgm_pkg::ENERGY_W-1:0] + w_gy2[sgm_pkg::ENERGY_W-1:0];

    sgm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_ENERGY),
        .i_value (w_energy[sgm_pkg::ROOT_IN_W-1:0]),
        .o_busy  (w_sqrt_busy),
        .o_root  (w_sqrt_root)
    );

    // The root is final once the unit drops busy; it may only move into the
    // output register when that register is empty or being emptied now.
    assign w_result_ready = (r_state == ST_SQRT) && !w_sqrt_busy;
    assign w_load_out     = w_result_ready && (!r_out_valid || !i_stall);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= sgm_pkg::WIDTH_RESET;
            r_cfg_height <= sgm_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sgm_pkg::CFG_IDX_WIDTH:  r_cfg_width  <= i_cfg_data[sgm_pkg::CFG_WW-1:0];
                sgm_pkg::CFG_IDX_HEIGHT: r_cfg_height <= i_cfg_data[sgm_pkg::CFG_HW-1:0];
                default: ;
            endcase
        end
    end

    // Line store: read on the accepted beat, written back in the next cycle
    // with the rows moved up by one. Only one pixel is in flight, so the
    // read and the write of an entry never overlap.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_rd <= mem_line[r_col];
        end
        if (r_state == ST_CALC) begin
            mem_line[r_col] <= {r_pix, r_rd[2*sgm_pkg::PIX_W-1:sgm_pkg::PIX_W]};
        end
    end

    // Sequencer, position counters and window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_col    <= '0;
            r_row    <= '0;
            r_window <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_accept) begin
                        r_state <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    r_window <= {r_window[3*sgm_pkg::PIX_W-1:0], r_pix, r_rd};
                    if (w_row_end) begin
                        r_col <= '0;
                        r_row <= w_img_end ? '0 : r_row + sgm_pkg::ROW_W'(1);
                    end else begin
                        r_col <= r_col + sgm_pkg::CNT_W'(1);
                    end
                    r_state <= w_interior ? ST_ENERGY : ST_IDLE;
                end
                ST_ENERGY: begin
                    r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (w_load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers between the sequencer steps.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_pix <= i_pixel;
        end
        if (r_state == ST_CALC) begin
            r_gx        <= w_gx[sgm_pkg::GRAD_W-1:0];
            r_gy        <= w_gy[sgm_pkg::GRAD_W-1:0];
            r_last_pend <= w_row_end && w_img_end;
        end
        if (r_state == ST_ENERGY) begin
            r_sat <= (w_energy[sgm_pkg::ENERGY_W-1:sgm_pkg::ROOT_IN_W] != '0);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_mag  <= r_sat ? sgm_pkg::MAG_SAT : w_sqrt_root;
            r_out_last <= r_last_pend;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_magnitude = r_out_mag;
    assign o_last      = r_out_last;

    // The root unit only runs while the sequencer waits on it.
    `SGM_ASSERT_IMP(a_sqrt_in_sqrt_state, w_sqrt_busy, r_state == ST_SQRT)
    // An accepted beat always moves on to the line store update.
    `SGM_ASSERT_NXT(a_accept_to_calc, w_in_accept, r_state == ST_CALC)
    // A new result appears only from a finished root computation.
    `SGM_ASSERT_IMP(a_result_from_sqrt, $rose(r_out_valid), $past(r_state == ST_SQRT))

endmodule

FILE: src/sgm_sqrt.sv
// Iterative floor square root: one result bit per cycle.
module sgm_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [sgm_pkg::ROOT_IN_W-1:0]   i_value,
    output logic                            o_busy,
    output logic [sgm_pkg::PIX_W-1:0]       o_root
);

    logic [sgm_pkg::ROOT_IN_W-1:0] r_val;
    logic [sgm_pkg::PIX_W-1:0]     r_root;
    logic [sgm_pkg::PIX_W-1:0]     r_bit;
    logic [sgm_pkg::PIX_W-1:0]     n_try;
    logic [sgm_pkg::ROOT_IN_W-1:0] n_sq;

    assign n_try = r_root | r_bit;
    assign n_sq  = n_try * n_try;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_start) begin
            r_bit <= {1'b1, {(sgm_pkg::PIX_W-1){1'b0}}};
        end else begin
            r_bit <= r_bit >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_root <= '0;
        end else if ((r_bit != '0) && (n_sq <= r_val)) begin
            r_root <= n_try;
        end
    end

    assign o_busy = (r_bit != '0);
    assign o_root = r_root;

endmodule

FILE: test/tb.sv
// Self-checking testbench for the streaming Sobel gradient magnitude filter.
module tb;
    import sgm_pkg::*;

    // Quiet cycles waited after the last result, long enough that no pixel is
    // still being worked on.
    localparam int SETTLE_CYCLES = 40;
    // Cycles without any beat or register write before the run is declared hung.
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_BEATS  = 750;

    typedef struct packed {
        logic [PIX_W-1:0] magnitude;
        logic             last;
    } edge_result_t;

    typedef enum int {STYLE_NOISE, STYLE_BINARY, STYLE_SMOOTH} pixel_style_t;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    logic [PIX_W-1:0]   i_pixel     = '0;
    logic               o_valid;
    logic               i_stall     = 1'b0;
    logic [PIX_W-1:0]   o_magnitude;
    logic               o_last;
    logic               i_cfg_we    = 1'b0;
    logic               i_cfg_index = 1'b0;
    logic [CFG_DW-1:0]  i_cfg_data  = '0;

    sobel_gradient_magnitude_stream DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_magnitude (o_magnitude),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: a private copy of the registers, line stores, window and
    // raster position, advanced once for every accepted pixel beat.
    // ------------------------------------------------------------------
    logic [CFG_WW-1:0] width_reg;
    logic [CFG_HW-1:0] height_reg;
    logic [PIX_W-1:0]  upper_row [0:MAX_WIDTH-1];
    logic [PIX_W-1:0]  middle_row [0:MAX_WIDTH-1];
    logic [47:0]       window_cols;
    int                line_col;
    int                line_row;

    edge_result_t      pending_edges [$];

    int pixels_sent    = 0;
    int results_seen   = 0;
    int reg_writes     = 0;
    int mismatch_count = 0;

    // Sender burst state and the level that the smooth pixel style wanders around.
    int burst_left     = 0;
    bit sender_steady  = 1'b0;
    int smooth_level   = 128;

    // Receiver stall pattern state.
    int stall_run      = 0;
    int free_run       = 0;

    function automatic int row_span();
        if (width_reg < 3)
            return 3;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int image_rows();
        if (height_reg < 3)
            return 3;
        return int'(height_reg);
    endfunction

    function automatic logic [PIX_W-1:0] floor_root(input int energy);
        logic [PIX_W-1:0] root;
        int               trial;
        root = '0;
        for (int b = PIX_W - 1; b >= 0; b--) begin
            trial = int'(root) | (1 << b);
            if (trial * trial <= energy)
                root = trial[PIX_W-1:0];
        end
        return root;
    endfunction

    task automatic clear_prediction();
        width_reg   = WIDTH_RESET;
        height_reg  = HEIGHT_RESET;
        window_cols = '0;
        line_col    = 0;
        line_row    = 0;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
    endtask

    // Advances the predictor by one pixel and queues the magnitude it causes.
    task automatic predict_magnitude(input logic [PIX_W-1:0] pix);
        int               span;
        int               rows;
        logic [PIX_W-1:0] above2;
        logic [PIX_W-1:0] above1;
        logic [23:0]      left_col;
        logic [23:0]      centre_col;
        logic [23:0]      right_col;
        int               lf [3];
        int               cn [3];
        int               rt [3];
        int               gx;
        int               gy;
        int               energy;
        edge_result_t     res;
        span   = row_span();
        rows   = image_rows();
        above2 = upper_row[line_col];
        above1 = middle_row[line_col];
        upper_row[line_col]  = above1;
        middle_row[line_col] = pix;

        left_col   = window_cols[47:24];
        centre_col = window_cols[23:0];
        right_col  = {pix, above1, above2};

        if (line_col >= 2 && line_row >= 2) begin
            // Row 0 of each column is the oldest line, row 2 the current one.
            for (int r = 0; r < 3; r++) begin
                lf[r] = int'(left_col[8*r +: 8]);
                cn[r] = int'(centre_col[8*r +: 8]);
                rt[r] = int'(right_col[8*r +: 8]);
            end
            gx = (rt[0] + 2 * rt[1] + rt[2]) - (lf[0] + 2 * lf[1] + lf[2]);
            gy = (lf[2] + 2 * cn[2] + rt[2]) - (lf[0] + 2 * cn[0] + rt[0]);
            energy = gx * gx + gy * gy;
            res.magnitude = (energy >= 65536) ? MAG_SAT : floor_root(energy);
            res.last      = (line_col >= span - 1 && line_row >= rows - 1);
            pending_edges.push_back(res);
        end

        window_cols = {centre_col, right_col};

        // A column already past the end of a shortened row wraps as well.
        if (line_col >= span - 1) begin
            line_col = 0;
            line_row = (line_row >= rows - 1) ? 0 : line_row + 1;
        end else begin
            line_col++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus side.
    // ------------------------------------------------------------------
    function automatic logic [PIX_W-1:0] next_pixel(input pixel_style_t style);
        case (style)
            STYLE_BINARY: begin
                return $urandom_range(0, 1) ? MAG_SAT : '0;
            end
            STYLE_SMOOTH: begin
                smooth_level += int'($urandom_range(0, 8)) - 4;
                if (smooth_level < 0)
                    smooth_level = 0;
                if (smooth_level > 255)
                    smooth_level = 255;
                return smooth_level[PIX_W-1:0];
            end
            default: begin
                return $urandom_range(0, 255);
            end
        endcase
    endfunction

    // Sends one pixel beat. Beats go out in bursts; between bursts the sender
    // may drop valid unless it is in a steady stretch.
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        if (burst_left == 0) begin
            if (!sender_steady) begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    @(negedge i_clk);
                    i_valid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_pixel <= pix;
        do @(posedge i_clk); while (o_stall);
        predict_magnitude(pix);
        pixels_sent++;
        burst_left--;
    endtask

    // Streams a fixed number of pixels, or, with to_end set, keeps going until
    // the raster position has wrapped back to the top left corner.
    task automatic stream_pixels(input int count, input bit to_end,
                                 input pixel_style_t style);
        int n;
        n = 0;
        while (to_end ? (n == 0 || line_col != 0 || line_row != 0) : (n < count)) begin
            send_pixel(next_pixel(style));
            n++;
        end
    endtask

    // Drops valid, waits for every queued magnitude and then lets any border
    // pixel still inside the block finish before registers are touched.
    task automatic settle_block();
        @(negedge i_clk);
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_edges.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [CFG_DW-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == CFG_IDX_WIDTH)
            width_reg = data[CFG_WW-1:0];
        else
            height_reg = data[CFG_HW-1:0];
        reg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Checking side.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        if (mismatch_count < 20)
            $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        edge_result_t wanted;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_edges.size() == 0) begin
                report_mismatch($sformatf("result beat (magnitude %0d, last %0b) not expected",
                                          o_magnitude, o_last));
            end else begin
                wanted = pending_edges.pop_front();
                if (o_magnitude !== wanted.magnitude)
                    report_mismatch($sformatf("magnitude %0d, expected %0d",
                                              o_magnitude, wanted.magnitude));
                if (o_last !== wanted.last)
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              o_last, wanted.last));
            end
        end
    end

    // The receiver alternates between clean stretches, choppy stalls and long
    // holds so that results back up against the block.
    always @(negedge i_clk) begin
        if (stall_run > 0) begin
            i_stall <= 1'b1;
            stall_run--;
        end else if (free_run > 0) begin
            i_stall <= 1'b0;
            free_run--;
        end else begin
            i_stall <= 1'b0;
            case ($urandom_range(0, 3))
                0: begin
                    free_run = $urandom_range(40, 200);
                end
                1: begin
                    stall_run = $urandom_range(1, 2);
                    free_run  = $urandom_range(1, 3);
                end
                2: begin
                    stall_run = $urandom_range(10, 30);
                    free_run  = $urandom_range(1, 10);
                end
                default: begin
                    stall_run = $urandom_range(0, 5);
                    free_run  = $urandom_range(5, 20);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset geometry (640 x 480): two full rows and the start of a third, so
    // a few interior pixels come out. The row is then cut to the minimum width
    // while the column count is well past it, and the height to below three,
    // so the very next pixel closes both its row and the image.
    task automatic test_reset_geometry();
        sender_steady = 1'b0;
        stream_pixels(2 * 640 + 12, 1'b0, STYLE_NOISE);
        settle_block();
        write_register(CFG_IDX_WIDTH, 16'd0);
        write_register(CFG_IDX_HEIGHT, 16'd2);
        stream_pixels(0, 1'b1, STYLE_NOISE);
        settle_block();
    endtask

    // Two 3 x 3 images with a single interior pixel each: a full-scale
    // vertical edge that saturates, and one whose energy sits just above 255
    // squared without reaching the saturation threshold.
    task automatic test_directed_edges();
        logic [PIX_W-1:0] frames [18];
        frames = '{8'd0, 8'd0, 8'd255,  8'd0, 8'd0, 8'd255,  8'd0, 8'd0, 8'd255,
                   8'd0, 8'd0, 8'd0,    8'd0, 8'd0, 8'd127,  8'd0, 8'd0, 8'd1};
        sender_steady = 1'b1;
        foreach (frames[i])
            send_pixel(frames[i]);
        settle_block();
    endtask

    // Widest row: a width value above the line store depth, with every upper
    // data bit set, is clamped to the full depth; three rows fill the stores.
    task automatic test_widest_row();
        write_register(CFG_IDX_WIDTH, 16'hFFFF);
        write_register(CFG_IDX_HEIGHT, 16'd3);
        sender_steady = 1'b0;
        stream_pixels(0, 1'b1, STYLE_BINARY);
        settle_block();
    endtask

    // Tallest image: start a 65535-row image, then drop the height below the
    // row already reached, so the current row becomes the last one.
    task automatic test_tall_image();
        write_register(CFG_IDX_WIDTH, 16'd4);
        write_register(CFG_IDX_HEIGHT, 16'hFFFF);
        sender_steady = 1'b0;
        stream_pixels(6 * 4 + 2, 1'b0, STYLE_SMOOTH);
        settle_block();
        write_register(CFG_IDX_HEIGHT, 16'd1);
        stream_pixels(0, 1'b1, STYLE_NOISE);
        settle_block();
    endtask

    // Random images. Geometry may grow only at the top left corner, because a
    // wider row in mid-image would read line store entries that hold nothing
    // yet; in mid-image the row may only shrink and the height may change
    // freely.
    task automatic test_random_images();
        int               start;
        logic [CFG_DW-1:0] raw;
        pixel_style_t     style;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_BEATS) begin
            if (line_col == 0 && line_row == 0) begin
                if ($urandom_range(0, 2) != 0) begin
                    case ($urandom_range(0, 9))
                        0:       raw = $urandom_range(0, 2);
                        1:       raw = $urandom_range(13, 48);
                        default: raw = $urandom_range(3, 12);
                    endcase
                    // Bits above the register width are don't-care.
                    raw[CFG_DW-1:CFG_WW] = $urandom;
                    write_register(CFG_IDX_WIDTH, raw);
                end
                if ($urandom_range(0, 2) != 0)
                    write_register(CFG_IDX_HEIGHT, ($urandom_range(0, 5) == 0) ?
                                   $urandom_range(0, 2) : $urandom_range(3, 7));
            end else begin
                if ($urandom_range(0, 3) == 0)
                    write_register(CFG_IDX_WIDTH, $urandom_range(0, row_span()));
                if ($urandom_range(0, 3) == 0)
                    write_register(CFG_IDX_HEIGHT, $urandom_range(0, 7));
            end
            sender_steady = ($urandom_range(0, 3) == 0);
            style = pixel_style_t'($urandom_range(0, 2));
            if ($urandom_range(0, 1))
                stream_pixels(0, 1'b1, style);
            else
                stream_pixels($urandom_range(1, 40), 1'b0, style);
            settle_block();
        end
    endtask

    // Hang detection: counts cycles in which no beat moves on either channel
    // and no register is written.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no beat for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_edges.size());
        $display("sobel_gradient_magnitude_stream verification failed");
        $finish;
    end

    initial begin
        clear_prediction();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_geometry();
        test_directed_edges();
        test_widest_row();
        test_tall_image();
        test_random_images();
        settle_block();

        $display("Run covered %0d pixel beats, %0d magnitude results and %0d register writes,",
                 pixels_sent, results_seen, reg_writes);
        $display("from 3-pixel rows up to the full line store and heights up to 65535 rows.");
        if (mismatch_count == 0)
            $display("sobel_gradient_magnitude_stream verification clean");
        else
            $display("sobel_gradient_magnitude_stream verification failed");
        $finish;
    end

endmodule
